// ===== rtl/core/websocket_frame_encoder_defines.svh =====
// Assertion macros shared by the WebSocket frame encoder RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef WEBSOCKET_FRAME_ENCODER_DEFINES_SVH
`define WEBSOCKET_FRAME_ENCODER_DEFINES_SVH

// The property must hold at every clock edge while out of reset.
`define WFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// The condition must never be true while out of reset.
`define WFE_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== rtl/core/wfe_pkg.sv =====
// Shared types, constants and helpers for the WebSocket frame encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package wfe_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = QPTR_W + 1;

  localparam int unsigned IDX_W       = 3;

  // Item selector on the input tuser
  typedef enum logic {
    FUNC_START   = 1'b0,
    FUNC_PAYLOAD = 1'b1
  } wfe_func_e;

  localparam logic [7:0]  HDR_FIN        = 8'h80;
  localparam logic        HDR_MASK_BIT   = 1'b1;
  localparam logic [6:0]  LEN_CODE_16    = 7'd126;
  localparam logic [15:0] LEN_SHORT_MAX  = 16'd125;
  localparam logic [IDX_W-1:0] HDR_LAST_SHORT = 3'd5;
  localparam logic [IDX_W-1:0] HDR_LAST_LONG  = 3'd7;
  localparam logic [IDX_W-1:0] KEY_BASE_SHORT = 3'd2;
  localparam logic [IDX_W-1:0] KEY_BASE_LONG  = 3'd4;

  // Command passed from the front to the back through the queue
  typedef struct packed {
    wfe_func_e   kind;
    logic [3:0]  opcode;
    logic [15:0] length;
    logic [31:0] key;
    logic [7:0]  data;       // already masked for payload commands
    logic        frame_end;
  } wfe_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } wfe_qstat_t;

  // Mask-key byte by position, position 0 is bits 31..24
  function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] sel);
    logic [7:0] b;
    unique case (sel)
      2'd0:    b = key[31:24];
      2'd1:    b = key[23:16];
      2'd2:    b = key[15:8];
      default: b = key[7:0];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wfe_front.sv =====
// Front end: accepts input items, tracks the open frame and masks payload bytes.
// Depends on wfe_pkg; feeds commands into wfe_queue.
`default_nettype none

module wfe_front
  import wfe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire wfe_func_e   func_i,
  input  wire logic [3:0]  opcode_i,
  input  wire logic [15:0] payload_length_i,
  input  wire logic [31:0] mask_key_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire wfe_qstat_t  qstat_i,
  output logic             push_o,
  output wfe_cmd_t         cmd_o
);

  logic [31:0] held_mask_q, held_mask_d;
  logic [15:0] bytes_left_q, bytes_left_d;
  logic [1:0]  mask_pos_q, mask_pos_d;
  logic        accept;
  logic        frame_open;

  assign in_ready_o = !qstat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign frame_open = (bytes_left_q != 16'd0);

  always_comb begin
    held_mask_d  = held_mask_q;
    bytes_left_d = bytes_left_q;
    mask_pos_d   = mask_pos_q;
    push_o       = 1'b0;

    cmd_o.kind      = func_i;
    cmd_o.opcode    = opcode_i;
    cmd_o.length    = payload_length_i;
    cmd_o.key       = mask_key_i;
    cmd_o.data      = data_byte_i ^ key_byte(held_mask_q, mask_pos_q);
    cmd_o.frame_end = (bytes_left_q == 16'd1);

    if (accept) begin
      unique case (func_i)
        FUNC_START: begin
          // restart: any open frame is abandoned
          push_o          = 1'b1;
          cmd_o.frame_end = (payload_length_i == 16'd0);
          held_mask_d     = mask_key_i;
          bytes_left_d    = payload_length_i;
          mask_pos_d      = 2'd0;
        end
        FUNC_PAYLOAD: begin
          // drop payload with no frame open
          if (frame_open) begin
            push_o       = 1'b1;
            bytes_left_d = bytes_left_q - 16'd1;
            mask_pos_d   = mask_pos_q + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_mask_q  <= '0;
      bytes_left_q <= '0;
      mask_pos_q   <= '0;
    end else begin
      held_mask_q  <= held_mask_d;
      bytes_left_q <= bytes_left_d;
      mask_pos_q   <= mask_pos_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wfe_queue.sv =====
// Short command queue between the front and the back of the frame encoder.
// Depends on wfe_pkg and the assertion macros header.
`default_nettype none
`include "websocket_frame_encoder_defines.svh"

module wfe_queue
  import wfe_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire wfe_cmd_t   cmd_i,
  input  wire logic       pop_i,
  output wfe_cmd_t        head_o,
  output wfe_qstat_t      qstat_o
);

  wfe_cmd_t            entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;

  assign qstat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign qstat_o.empty = (count_q == '0);
  assign head_o        = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `WFE_NEVER(a_no_overflow, push_i && qstat_o.full && !pop_i, "push into a full queue")
  `WFE_NEVER(a_no_underflow, pop_i && qstat_o.empty, "pop from an empty queue")
  `WFE_ASSERT(a_count_ptrs, (count_q == QCNT_W'(QUEUE_DEPTH)) || (count_q[QPTR_W-1:0] == (wr_ptr_q - rd_ptr_q)), "queue count out of step with pointers")

endmodule

`default_nettype wire

// ===== rtl/core/wfe_back.sv =====
// Back end: expands queued commands into frame bytes behind an output register.
// Depends on wfe_pkg and the assertion macros header.
`default_nettype none
`include "websocket_frame_encoder_defines.svh"

module wfe_back
  import wfe_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire wfe_cmd_t   head_i,
  input  wire wfe_qstat_t qstat_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o,
  output logic            frame_end_o
);

  logic [IDX_W-1:0] idx_q, idx_d;
  logic             valid_q, valid_d;
  logic [7:0]       byte_q;
  logic             last_q;
  logic             end_q;

  logic             load;
  logic             take;
  logic             long_len;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] key_off;
  logic [7:0]       nxt_byte;
  logic             nxt_last;
  logic             nxt_end;

  assign load     = !valid_q || out_ready_i;
  assign take     = load && !qstat_i.empty;
  assign long_len = (head_i.length > LEN_SHORT_MAX);
  assign last_idx = long_len ? HDR_LAST_LONG : HDR_LAST_SHORT;
  assign key_off  = idx_q - (long_len ? KEY_BASE_LONG : KEY_BASE_SHORT);

  always_comb begin
    nxt_byte = key_byte(head_i.key, key_off[1:0]);
    nxt_last = 1'b1;
    nxt_end  = head_i.frame_end;
    if (head_i.kind == FUNC_PAYLOAD) begin
      nxt_byte = head_i.data;
    end else begin
      nxt_last = (idx_q == last_idx);
      nxt_end  = nxt_last && head_i.frame_end;
      priority if (idx_q == IDX_W'(0)) begin
        nxt_byte = HDR_FIN | {4'b0000, head_i.opcode};
      end else if (idx_q == IDX_W'(1)) begin
        nxt_byte = long_len ? {HDR_MASK_BIT, LEN_CODE_16}
                            : {HDR_MASK_BIT, head_i.length[6:0]};
      end else if (long_len && idx_q == IDX_W'(2)) begin
        nxt_byte = head_i.length[15:8];
      end else if (long_len && idx_q == IDX_W'(3)) begin
        nxt_byte = head_i.length[7:0];
      end else begin
        nxt_byte = key_byte(head_i.key, key_off[1:0]);
      end
    end
  end

  always_comb begin
    pop_o   = take && nxt_last;
    idx_d   = idx_q;
    valid_d = valid_q;
    if (take) begin
      idx_d   = nxt_last ? '0 : idx_q + IDX_W'(1);
      valid_d = 1'b1;
    end else if (load) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // hold the payload while the sink stalls
  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= nxt_byte;
      last_q <= nxt_last;
      end_q  <= nxt_end;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign run_last_o  = last_q;
  assign frame_end_o = end_q;

  `WFE_ASSERT(a_end_is_last, valid_q && end_q |-> last_q, "frame end without run end")
  `WFE_ASSERT(a_idx_in_header, idx_q != '0 |-> !qstat_i.empty && head_i.kind == FUNC_START, "header index set without a header in progress")
  `WFE_NEVER(a_short_hdr_bound, !qstat_i.empty && head_i.kind == FUNC_START && !long_len && idx_q > HDR_LAST_SHORT, "short header ran past its last byte")

endmodule

`default_nettype wire

// ===== rtl/core/websocket_frame_encoder.sv =====
// Top level of the client-side WebSocket frame encoder (masked byte stream).
// Depends on wfe_pkg, wfe_front, wfe_queue and wfe_back.
//
//   channel   dir  tdata                                    tuser        tlast
//   s_axis    in   opcode, payload_length, mask_key, byte   func         -
//   m_axis    out  out_byte                                 frame_end    run_last
//
// A payload item on an open frame yields one byte; a start item yields six bytes
// (lengths up to 125) or eight, sent by the back end one byte per cycle unless stalled.
// The front takes an item every cycle while the four-entry command queue has
// room, so headers are absorbed while the back drains earlier work.
// Output stalls hold the output register and back up into the queue.
// Reset clears the frame state, queue pointers and output valid; no clearing pass.
`default_nettype none

module websocket_frame_encoder
  import wfe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [3:0] opcode, [19:4] payload_length, [51:20] mask_key, [59:52] data_byte, [63:60] zero
  input  wire logic [63:0] s_axis_tdata_i,
  // [0] func
  input  wire logic        s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [7:0] out_byte
  output logic [7:0]       m_axis_tdata_o,
  // [0] run_last
  output logic             m_axis_tlast_o,
  // [0] frame_end
  output logic             m_axis_tuser_o
);

  wfe_qstat_t qstat;
  wfe_cmd_t   push_cmd;
  wfe_cmd_t   head_cmd;
  logic       push;
  logic       pop;
  wfe_func_e  func;

  assign func = wfe_func_e'(s_axis_tuser_i);

  wfe_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid_i),
    .in_ready_o       (s_axis_tready_o),
    .func_i           (func),
    .opcode_i         (s_axis_tdata_i[3:0]),
    .payload_length_i (s_axis_tdata_i[19:4]),
    .mask_key_i       (s_axis_tdata_i[51:20]),
    .data_byte_i      (s_axis_tdata_i[59:52]),
    .qstat_i          (qstat),
    .push_o           (push),
    .cmd_o            (push_cmd)
  );

  wfe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .head_o  (head_cmd),
    .qstat_o (qstat)
  );

  wfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .run_last_o  (m_axis_tlast_o),
    .frame_end_o (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

// ===== sim/websocket_frame_encoder_tb.sv =====
// Self-checking bench for websocket_frame_encoder: masked client frames on a byte stream.
// Depends on wfe_pkg and the encoder RTL; drives stimulus at the falling edge and
// checks every output byte against a local frame predictor or a typed row's bytes.
`default_nettype none

module websocket_frame_encoder_tb
  import wfe_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_REQS  = 180;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned PLAN_ROWS    = 24;

  // One input request; a typed row carries its expected bytes, first byte in the top bits
  typedef struct packed {
    wfe_func_e   func;
    logic [3:0]  opcode;
    logic [15:0] length;
    logic [31:0] key;
    logic [7:0]  data;
    logic        typed;
    logic [3:0]  n_typed;
    logic [63:0] typed_bytes;
    logic        typed_end;
  } enc_req_t;

  typedef struct packed {
    logic [7:0] wire_byte;
    logic       run_last;
    logic       frame_end;
  } wire_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i;
  logic        s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        m_axis_tuser_o;

  // Predictor state
  logic [31:0] frame_key;
  logic [15:0] payload_left;
  logic [1:0]  key_pos;

  wire_beat_t  bytes_due[$];
  enc_req_t    plan [PLAN_ROWS];

  int unsigned errors        = 0;
  int unsigned live_reqs     = 0;
  int unsigned starts_sent   = 0;
  int unsigned beats_checked = 0;
  int unsigned frames_closed = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned sink_wait     = 0;
  bit          src_burst     = 0;
  bit          sink_burst    = 0;

  websocket_frame_encoder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Work out the wire bytes for one request and advance the frame state.
  function automatic int unsigned predict_frame_bytes(input enc_req_t r, input bit push);
    wire_beat_t  beats[$];
    logic [15:0] len;
    logic        end_now;
    len = r.length;
    if (r.func == FUNC_START) begin
      end_now = (len == 16'd0);
      beats.push_back('{8'h80 | {4'h0, r.opcode}, 1'b0, 1'b0});
      if (len > 16'd125) begin
        beats.push_back('{8'h80 | 8'd126, 1'b0, 1'b0});
        beats.push_back('{len[15:8], 1'b0, 1'b0});
        beats.push_back('{len[7:0], 1'b0, 1'b0});
      end else begin
        beats.push_back('{8'h80 | len[7:0], 1'b0, 1'b0});
      end
      for (int k = 0; k < 4; k++) begin
        beats.push_back('{r.key[31 - 8 * k -: 8], k == 3, (k == 3) && end_now});
      end
      frame_key    = r.key;
      payload_left = len;
      key_pos      = 2'd0;
    end else if (payload_left != 16'd0) begin
      payload_left = payload_left - 16'd1;
      beats.push_back('{r.data ^ frame_key[31 - 8 * key_pos -: 8], 1'b1, payload_left == 16'd0});
      key_pos = key_pos + 2'd1;
    end
    if (push) begin
      foreach (beats[i]) bytes_due.push_back(beats[i]);
    end
    return beats.size();
  endfunction

  // Offer one request after a random gap and hold it until the encoder takes it.
  task automatic send_request(input enc_req_t r);
    int unsigned gap;
    int unsigned n_model;
    gap = src_burst ? 0 : $urandom_range(0, 16);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= r.func;
    s_axis_tdata_i  <= {4'h0, r.data, r.key, r.length, r.opcode};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    n_model = predict_frame_bytes(r, !r.typed);
    if (n_model > 0) live_reqs++;
    if (r.func == FUNC_START) starts_sent++;
    if (r.typed) begin
      for (int k = 0; k < r.n_typed; k++) begin
        bytes_due.push_back('{r.typed_bytes[63 - 8 * k -: 8], k == r.n_typed - 1,
                              (k == r.n_typed - 1) && r.typed_end});
      end
    end
  endtask

  // Sink: hold tready low for the drawn number of cycles after each byte.
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_wait > 0) begin
        m_axis_tready_i <= 1'b0;
        sink_wait--;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    wire_beat_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (bytes_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte: expected none, actual %02h last=%b end=%b",
                 $realtime, m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
      end else begin
        want = bytes_due.pop_front();
        if (m_axis_tdata_o !== want.wire_byte) begin
          errors++;
          $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                   $realtime, want.wire_byte, m_axis_tdata_o);
        end
        if (m_axis_tlast_o !== want.run_last) begin
          errors++;
          $display("%0t: run_last mismatch: expected %b, actual %b",
                   $realtime, want.run_last, m_axis_tlast_o);
        end
        if (m_axis_tuser_o !== want.frame_end) begin
          errors++;
          $display("%0t: frame_end mismatch: expected %b, actual %b",
                   $realtime, want.frame_end, m_axis_tuser_o);
        end
      end
      beats_checked++;
      if (m_axis_tuser_o === 1'b1) frames_closed++;
      if (beats_checked % 32 == 0) sink_burst = ($urandom_range(0, 3) == 0);
      sink_wait = sink_burst ? 0 : $urandom_range(0, 16);
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("%0t: run timed out after %0d cycles, %0d bytes outstanding",
             $realtime, cycle_cnt, bytes_due.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    enc_req_t    r;
    int unsigned target;
    int unsigned pick;
    int unsigned n_pay;

    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 64'h0;
    s_axis_tuser_i  = FUNC_START;
    frame_key       = 32'h0;
    payload_left    = 16'h0;
    key_pos         = 2'd0;

    // Payload with no frame open, carrying junk in the header fields: dropped
    plan[0]  = '{FUNC_PAYLOAD, 4'hf, 16'hffff, 32'hffff_ffff, 8'h55, 1'b1, 4'd0, 64'h0, 1'b0};
    // Zero-length frame closes on the last key byte
    plan[1]  = '{FUNC_START, 4'hf, 16'd0, 32'hffff_ffff, 8'hff, 1'b1, 4'd6,
                 64'h8f80_ffff_ffff_0000, 1'b1};
    plan[2]  = '{FUNC_PAYLOAD, 4'h0, 16'd0, 32'h0, 8'h00, 1'b1, 4'd0, 64'h0, 1'b0};
    plan[3]  = '{FUNC_START, 4'h0, 16'hffff, 32'h0, 8'h00, 1'b1, 4'd8,
                 64'h80fe_ffff_0000_0000, 1'b0};
    plan[4]  = '{FUNC_PAYLOAD, 4'h0, 16'd0, 32'h0, 8'haa, 1'b1, 4'd1, 64'haa00_0000_0000_0000, 1'b0};
    plan[5]  = '{FUNC_PAYLOAD, 4'hf, 16'hffff, 32'hffff_ffff, 8'hff, 1'b1, 4'd1,
                 64'hff00_0000_0000_0000, 1'b0};
    // Restart while the long frame is still open
    plan[6]  = '{FUNC_START, 4'h1, 16'd125, 32'h1234_5678, 8'h00, 1'b1, 4'd6,
                 64'h81fd_1234_5678_0000, 1'b0};
    plan[7]  = '{FUNC_START, 4'h2, 16'd126, 32'ha5a5_a5a5, 8'h00, 1'b1, 4'd8,
                 64'h82fe_007e_a5a5_a5a5, 1'b0};
    plan[8]  = '{FUNC_START, 4'h8, 16'd5, 32'hdead_beef, 8'h3c, 1'b0, 4'd0, 64'h0, 1'b0};
    plan[9]  = '{FUNC_PAYLOAD, 4'h0, 16'd0, 32'h0, 8'h00, 1'b0, 4'd0, 64'h0, 1'b0};
    plan[10] = '{FUNC_PAYLOAD, 4'h0, 16'd0, 32'h0, 8'hff, 1'b0, 4'd0, 64'h0, 1'b0};
    plan[11] = '{FUNC_PAYLOAD, 4'h5, 16'h1234, 32'h0, 8'h3c, 1'b0, 4'd0, 64'h0, 1'b0};
    plan[12] = '{FUNC_PAYLOAD, 4'h0, 16'd0, 32'h0, 8'hc3, 1'b0, 4'd0, 64'h0, 1'b0};
    plan[13] = '{FUNC_PAYLOAD, 4'h0, 16'd0, 32'h0, 8'h81, 1'b0, 4'd0, 64'h0, 1'b0};
    // Frame complete: the next byte has nowhere to go
    plan[14] = '{FUNC_PAYLOAD, 4'h0, 16'd0, 32'h0, 8'h77, 1'b1, 4'd0, 64'h0, 1'b0};
    plan[15] = '{FUNC_START, 4'h9, 16'd1, 32'h0102_0304, 8'h00, 1'b0, 4'd0, 64'h0, 1'b0};
    plan[16] = '{FUNC_PAYLOAD, 4'h0, 16'd0, 32'h0, 8'h10, 1'b0, 4'd0, 64'h0, 1'b0};
    plan[17] = '{FUNC_START, 4'ha, 16'd2, 32'h8000_0001, 8'h00, 1'b0, 4'd0, 64'h0, 1'b0};
    plan[18] = '{FUNC_PAYLOAD, 4'h0, 16'd0, 32'h0, 8'hfe, 1'b0, 4'd0, 64'h0, 1'b0};
    plan[19] = '{FUNC_START, 4'h3, 16'd256, 32'hcafe_f00d, 8'h00, 1'b0, 4'd0, 64'h0, 1'b0};
    plan[20] = '{FUNC_PAYLOAD, 4'h0, 16'd0, 32'h0, 8'h00, 1'b0, 4'd0, 64'h0, 1'b0};
    plan[21] = '{FUNC_START, 4'h7, 16'd124, 32'h0, 8'h00, 1'b0, 4'd0, 64'h0, 1'b0};
    plan[22] = '{FUNC_PAYLOAD, 4'h0, 16'd0, 32'h0, 8'h01, 1'b0, 4'd0, 64'h0, 1'b0};
    plan[23] = '{FUNC_START, 4'h4, 16'd3, 32'hffff_ffff, 8'h00, 1'b0, 4'd0, 64'h0, 1'b0};

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) send_request(plan[i]);

    // Random frames: mostly well-formed with random content, some cut short
    target = live_reqs + RANDOM_REQS;
    while (live_reqs < target) begin
      src_burst = ($urandom_range(0, 4) == 0);
      r = '0;
      r.func   = FUNC_START;
      r.opcode = 4'($urandom_range(0, 15));
      r.key    = $urandom();
      r.data   = 8'($urandom_range(0, 255));
      pick     = $urandom_range(0, 99);
      if (pick < 65)      r.length = 16'($urandom_range(0, 12));
      else if (pick < 80) r.length = 16'($urandom_range(120, 131));
      else if (pick < 92) r.length = 16'($urandom_range(132, 65535));
      else if (pick < 96) r.length = 16'hffff;
      else                r.length = $urandom_range(0, 1) ? 16'd125 : 16'd126;
      if (r.length <= 40 && $urandom_range(0, 9) < 8) n_pay = 32'(r.length);
      else n_pay = $urandom_range(0, (r.length < 24) ? 32'(r.length) : 24);
      send_request(r);
      for (int k = 0; k < n_pay; k++) begin
        r.func   = FUNC_PAYLOAD;
        r.opcode = 4'($urandom_range(0, 15));
        r.length = 16'($urandom_range(0, 65535));
        r.key    = $urandom();
        r.data   = 8'($urandom_range(0, 255));
        send_request(r);
      end
      // Stray bytes after a closed frame
      if (payload_left == 16'd0 && $urandom_range(0, 9) == 0) begin
        r.func = FUNC_PAYLOAD;
        r.data = 8'($urandom_range(0, 255));
        send_request(r);
      end
    end

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (bytes_due.size() != 0) begin
      errors += bytes_due.size();
      $display("%0t: %0d expected bytes never arrived", $realtime, bytes_due.size());
    end
    $display("Covered %0d live requests (%0d frame starts), %0d output bytes checked,",
             live_reqs, starts_sent, beats_checked);
    $display("%0d frames closed, %0d mismatches, %0d cycles", frames_closed, errors, cycle_cnt);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
